// File: hw/rtl/hta_pkg.sv
// Shared types and constants for the handle table with unique ID allocation.
// No dependencies; imported by handle_table_id_allocator.
package hta_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int ID_BITS     = 31;
   localparam int TAG_BITS    = 32;
   localparam int SLOT_BITS   = $clog2(TABLE_DEPTH);

   localparam logic [ID_BITS-1:0] ID_MAX = {ID_BITS{1'b1}};

   typedef enum logic [1:0] {
      CMD_ADD        = 2'd0,
      CMD_REMOVE     = 2'd1,
      CMD_LOOKUP_ID  = 2'd2,
      CMD_LOOKUP_OBJ = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_FULL = 2'd1,
      STATUS_MISS = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WAIT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [TAG_BITS-1:0] obj;
      logic [ID_BITS-1:0]  id;
   } slot_entry_type;

endpackage

// File: hw/rtl/handle_table_id_allocator.sv
// Handle table: slots of {object tag, unique ID} in one synchronous memory.
// Depends on hta_pkg for widths, command/status codes and the entry type.
//
//   channel | direction | handshake          | word
//   req     | in        | req_valid/stall    | cmd, obj_tag, query_id
//   rsp     | out       | rsp_valid/stall    | status, result_id, result_obj, slot_index
//
// Every command runs from accept to the next accept in the same order: one sweep of
// TABLE_DEPTH memory reads through the single read port, a wait state for the
// last read data, a commit that loads the result register, and a return to
// idle, in which the next word is taken.
// An add resolves ID collisions within that same sweep by marking which of
// the next TABLE_DEPTH candidate IDs are held, so it needs no extra sweep.
// Reset clears the occupancy bits and the last-issued ID; the memory is not
// swept. A stalled result holds the block in its commit cycle.
module handle_table_id_allocator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  hta_pkg::cmd_type                  req_cmd,
   input  logic [hta_pkg::TAG_BITS-1:0]      req_obj_tag,
   input  logic [hta_pkg::ID_BITS-1:0]       req_query_id,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output hta_pkg::status_type               rsp_status,
   output logic [hta_pkg::ID_BITS-1:0]       rsp_result_id,
   output logic [hta_pkg::TAG_BITS-1:0]      rsp_result_obj,
   output logic [hta_pkg::SLOT_BITS-1:0]     rsp_slot_index
);
   import hta_pkg::*;

   // control state
   state_type              state_ff, state_in;
   logic [SLOT_BITS-1:0]   cnt_ff, cnt_in;
   logic                   chk_valid_ff;
   logic [TABLE_DEPTH-1:0] occ_ff;
   logic [ID_BITS-1:0]     last_id_ff;
   logic                   rsp_valid_ff;

   // request and scan payload
   cmd_type                cmd_ff;
   logic [TAG_BITS-1:0]    tag_ff;
   logic [ID_BITS-1:0]     qid_ff;
   logic [ID_BITS-1:0]     base_ff;
   logic [SLOT_BITS-1:0]   chk_addr_ff;
   logic                   hit_ff;
   logic [SLOT_BITS-1:0]   hit_slot_ff;
   logic [TAG_BITS-1:0]    hit_obj_ff;
   logic [ID_BITS-1:0]     hit_id_ff;
   logic [TABLE_DEPTH-1:0] blocked_ff;

   // result register
   status_type             rsp_status_ff;
   logic [ID_BITS-1:0]     rsp_id_ff;
   logic [TAG_BITS-1:0]    rsp_obj_ff;
   logic [SLOT_BITS-1:0]   rsp_slot_ff;

   // memory
   slot_entry_type         mem [TABLE_DEPTH];
   slot_entry_type         rd_data_ff;
   slot_entry_type         mem_wdata;
   logic                   mem_re;
   logic                   mem_we;

   logic                   accept;
   logic                   rsp_load;
   logic                   chk_occ;
   logic                   match;
   logic [ID_BITS-1:0]     id_m1;
   logic [ID_BITS-1:0]     id_gap;
   logic                   blk_hit;
   logic                   free_found;
   logic [SLOT_BITS-1:0]   free_slot;
   logic [SLOT_BITS-1:0]   open_k;
   logic [ID_BITS:0]       cand_sum;
   logic [ID_BITS-1:0]     new_id;
   logic                   add_commit;
   logic                   remove_commit;
   status_type             status_in;
   logic [ID_BITS-1:0]     res_id_in;
   logic [TAG_BITS-1:0]    res_obj_in;
   logic [SLOT_BITS-1:0]   res_slot_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // ---------------- memory ----------------
   assign mem_wdata = '{obj: tag_ff, id: new_id};
   assign mem_we    = rsp_load && add_commit;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[free_slot] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[cnt_ff];
      end
   end

   // ---------------- scan compare ----------------
   assign chk_occ = occ_ff[chk_addr_ff];

   always_comb begin
      if (cmd_ff == CMD_LOOKUP_ID) begin
         match = chk_occ && (qid_ff != '0) && (rd_data_ff.id == qid_ff);
      end else begin
         match = chk_occ && (rd_data_ff.obj == tag_ff);
      end
   end

   // distance of a held ID from the first candidate, modulo the ID range
   assign id_m1   = rd_data_ff.id - ID_BITS'(1);
   assign id_gap  = (id_m1 < base_ff) ? (id_m1 - base_ff - ID_BITS'(1)) : (id_m1 - base_ff);
   assign blk_hit = chk_occ && (id_gap < ID_BITS'(TABLE_DEPTH));

   // ---------------- add: free slot and ID pick ----------------
   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
         if (!occ_ff[i]) begin
            free_found = 1'b1;
            free_slot  = SLOT_BITS'(i);
         end
      end
   end

   always_comb begin
      open_k = '0;
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
         if (!blocked_ff[i]) begin
            open_k = SLOT_BITS'(i);
         end
      end
   end

   // wrap past the largest ID back to 1
   assign cand_sum = {1'b0, base_ff} + (ID_BITS+1)'(open_k) + (ID_BITS+1)'(1);
   assign new_id   = (cand_sum > {1'b0, ID_MAX}) ? ID_BITS'(cand_sum - {1'b0, ID_MAX})
                                                 : ID_BITS'(cand_sum);

   // ---------------- result select ----------------
   always_comb begin
      status_in     = STATUS_MISS;
      res_id_in     = '0;
      res_obj_in    = '0;
      res_slot_in   = '0;
      add_commit    = 1'b0;
      remove_commit = 1'b0;
      unique case (cmd_ff)
         CMD_ADD: begin
            if (tag_ff == '0) begin
               status_in = STATUS_MISS;
            end else if (!free_found) begin
               status_in = STATUS_FULL;
            end else begin
               status_in   = STATUS_OK;
               res_id_in   = new_id;
               res_slot_in = free_slot;
               add_commit  = 1'b1;
            end
         end
         CMD_REMOVE: begin
            if (hit_ff) begin
               status_in     = STATUS_OK;
               res_slot_in   = hit_slot_ff;
               remove_commit = 1'b1;
            end
         end
         CMD_LOOKUP_ID: begin
            if (hit_ff) begin
               status_in   = STATUS_OK;
               res_obj_in  = hit_obj_ff;
               res_slot_in = hit_slot_ff;
            end
         end
         CMD_LOOKUP_OBJ: begin
            if (hit_ff) begin
               status_in   = STATUS_OK;
               res_id_in   = hit_id_ff;
               res_slot_in = hit_slot_ff;
            end
         end
         default: begin
            status_in = STATUS_MISS;
         end
      endcase
   end

   // ---------------- sequencer ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         chk_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         chk_valid_ff <= mem_re;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      mem_re   = 1'b0;
      rsp_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
               cnt_in   = '0;
            end
         end
         ST_SCAN: begin
            mem_re = 1'b1;
            cnt_in = cnt_ff + SLOT_BITS'(1);
            if (cnt_ff == SLOT_BITS'(TABLE_DEPTH - 1)) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the result register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------- table state ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff     <= '0;
         last_id_ff <= '0;
      end else if (rsp_load) begin
         if (add_commit) begin
            occ_ff[free_slot] <= 1'b1;
            last_id_ff        <= new_id;
         end
         if (remove_commit) begin
            occ_ff[hit_slot_ff] <= 1'b0;
         end
      end
   end

   // ---------------- request and scan payload ----------------
   always_ff @(posedge clock) begin
      if (mem_re) begin
         chk_addr_ff <= cnt_ff;
      end
      if (accept) begin
         cmd_ff     <= req_cmd;
         tag_ff     <= req_obj_tag;
         qid_ff     <= req_query_id;
         base_ff    <= (last_id_ff == ID_MAX) ? '0 : last_id_ff;
         hit_ff     <= 1'b0;
         blocked_ff <= '0;
      end else if (chk_valid_ff) begin
         // keep the first match only
         if (match && !hit_ff) begin
            hit_ff      <= 1'b1;
            hit_slot_ff <= chk_addr_ff;
            hit_obj_ff  <= rd_data_ff.obj;
            hit_id_ff   <= rd_data_ff.id;
         end
         if (blk_hit) begin
            blocked_ff[id_gap[SLOT_BITS-1:0]] <= 1'b1;
         end
      end
   end

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= status_in;
         rsp_id_ff     <= res_id_in;
         rsp_obj_ff    <= res_obj_in;
         rsp_slot_ff   <= res_slot_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_result_id  = rsp_id_ff;
   assign rsp_result_obj = rsp_obj_ff;
   assign rsp_slot_index = rsp_slot_ff;

   // ---------------- assertions ----------------
   a_load_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result loaded outside the commit state");

   a_chk_in_scan: assert property (@(posedge clock) disable iff (reset)
      chk_valid_ff |-> (state_ff == ST_SCAN || state_ff == ST_WAIT))
      else $error("read data checked outside the sweep");

   a_id_available: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && cmd_ff == CMD_ADD && !(&occ_ff)) |-> !(&blocked_ff))
      else $error("no free ID among the candidates");

   a_full_only_when_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && status_in == STATUS_FULL) |-> (&occ_ff))
      else $error("full reported with a free slot");

endmodule
